FILE: hw/rtl/otsu_pkg.sv
// ----------------------------------------------------------------------------
// Otsu threshold package
// Shared widths and constants for the histogram threshold finder.
// ----------------------------------------------------------------------------
package otsu_pkg;

   localparam int PIX_W       = 8;
   localparam int GRAY_LEVELS = 256;
   localparam int BIN_SLOTS   = 256;
   localparam int BIN_AW      = $clog2(BIN_SLOTS);
   localparam int MAX_PIXELS  = 1048576;
   localparam int CNT_W       = $clog2(MAX_PIXELS) + 1;
   localparam int SUM_W       = PIX_W + CNT_W - 1;
   localparam int D_W         = SUM_W + CNT_W;
   localparam int NUM_W       = 2 * D_W;
   localparam int DEN_W       = 2 * CNT_W;
   localparam int CMP_W       = NUM_W + DEN_W;
   localparam int MCNT_W      = $clog2(D_W);

   localparam logic [PIX_W-1:0] TOP_LEVEL = PIX_W'(GRAY_LEVELS - 1);

endpackage

FILE: hw/rtl/otsu_ram.sv
// ----------------------------------------------------------------------------
// Otsu generic RAM
// One write port, one read port, read data registered (data for an address comes out in the next cycle).
// ----------------------------------------------------------------------------
module otsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hw/rtl/otsu_threshold_finder.sv
// ----------------------------------------------------------------------------
// Otsu threshold finder
// Builds a gray-level histogram of one frame and picks the Otsu threshold.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one pixel word per cycle (req_pixel, req_last_pixel). Pixels
//  are taken at one per cycle while a frame is collected; the histogram bin
//  is updated by read-modify-write on a one-port-read RAM with forwarding.
//  After the word marked last, req_stall stays high during the scan.
//  Scan: one pass over all levels; a level whose class is empty or full
//  passes only RD, BIN and UPD, any other level also PRD, DEN, SQ, LHS,
//  RHS and CMP, where the cost is the shared shift-add multiplier (49
//  steps each for the square and the two cross products). Level 0 always
//  has an empty class. The scan also writes every bin back to zero, so no
//  separate clear pass.
//  rsp channel: one threshold word per frame, held in an output register
//  until rsp_stall is low; a new frame may be collected meanwhile, and a
//  finished scan waits until the previous result word has left.
//  Reset: synchronous; starts a clearing pass over all 256 histogram
//  bins, during which req_stall is high.
// ----------------------------------------------------------------------------
module otsu_threshold_finder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [otsu_pkg::PIX_W-1:0] req_pixel,
   input  logic                      req_last_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [otsu_pkg::PIX_W-1:0] rsp_threshold
);

   typedef enum logic [12:0] {
      S_ACC  = 13'b0000000000001,
      S_WAIT = 13'b0000000000010,
      S_RD   = 13'b0000000000100,
      S_BIN  = 13'b0000000001000,
      S_PRD  = 13'b0000000010000,
      S_DEN  = 13'b0000000100000,
      S_SQ   = 13'b0000001000000,
      S_LHS  = 13'b0000010000000,
      S_RHS  = 13'b0000100000000,
      S_CMP  = 13'b0001000000000,
      S_UPD  = 13'b0010000000000,
      S_FIN  = 13'b0100000000000,
      S_CLR  = 13'b1000000000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [otsu_pkg::CNT_W-1:0]       frame_count_ff, frame_count_in;
   logic [otsu_pkg::SUM_W-1:0]       mt_ff, mt_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic [otsu_pkg::BIN_AW-1:0]      s1_addr_ff;
   logic                             wl_valid_ff;
   logic [otsu_pkg::BIN_AW-1:0]      wl_addr_ff;
   logic [otsu_pkg::CNT_W-1:0]       wl_data_ff;
   logic [otsu_pkg::PIX_W-1:0]       t_ff, t_in;
   logic [otsu_pkg::CNT_W-1:0]       w_ff, w_in;
   logic [otsu_pkg::SUM_W-1:0]       m_ff, m_in;
   logic [otsu_pkg::CNT_W-1:0]       bin_ff;
   logic [otsu_pkg::D_W-1:0]         a_ff, b_ff;
   logic [otsu_pkg::DEN_W-1:0]       den_ff;
   logic [otsu_pkg::NUM_W-1:0]       num_ff;
   logic [otsu_pkg::CMP_W-1:0]       lhs_ff;
   logic [otsu_pkg::NUM_W-1:0]       best_num_ff;
   logic [otsu_pkg::DEN_W-1:0]       best_den_ff;
   logic [otsu_pkg::PIX_W-1:0]       best_t_ff;
   logic                             best_upd;
   logic [otsu_pkg::CMP_W-1:0]       mul_a_ff, mul_a_in;
   logic [otsu_pkg::D_W-1:0]         mul_b_ff, mul_b_in;
   logic [otsu_pkg::CMP_W-1:0]       mul_acc_ff, mul_acc_in, mul_step;
   logic [otsu_pkg::MCNT_W-1:0]      mul_cnt_ff, mul_cnt_in;
   logic                             mul_last;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [otsu_pkg::PIX_W-1:0]       rsp_threshold_ff;
   logic                             accept, count_pix, skip_lvl;
   logic [otsu_pkg::PIX_W-1:0]       lvl;
   logic [otsu_pkg::CNT_W-1:0]       base, inc;
   logic                             ram_we;
   logic [otsu_pkg::BIN_AW-1:0]      ram_waddr, ram_raddr;
   logic [otsu_pkg::CNT_W-1:0]       ram_wdata, ram_rdata;
   logic [otsu_pkg::D_W-1:0]         d_val;

   otsu_ram #(
      .WIDTH (otsu_pkg::CNT_W),
      .DEPTH (otsu_pkg::BIN_SLOTS)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall     = (state_ff != S_ACC);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;

   assign accept    = req_valid && !req_stall;
   assign lvl       = (req_pixel > otsu_pkg::TOP_LEVEL) ? otsu_pkg::TOP_LEVEL : req_pixel;
   assign count_pix = accept &&
                      (frame_count_ff < otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS));

   // forward the write made at the edge where this read was taken
   assign base = (wl_valid_ff && wl_addr_ff == s1_addr_ff) ? wl_data_ff : ram_rdata;
   assign inc  = base + otsu_pkg::CNT_W'(1);

   assign skip_lvl = (w_ff == '0) || (w_ff == frame_count_ff);
   assign d_val    = (a_ff > b_ff) ? (a_ff - b_ff) : (b_ff - a_ff);
   assign mul_step = mul_acc_ff + (mul_b_ff[0] ? mul_a_ff : '0);
   assign mul_last = (mul_cnt_ff == otsu_pkg::MCNT_W'(otsu_pkg::D_W - 1));
   assign best_upd = (lhs_ff > mul_acc_ff);

   always_comb begin
      ram_raddr = (state_ff == S_ACC) ? lvl : t_ff;
      if (s1_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = s1_addr_ff;
         ram_wdata = inc;
      end else begin
         ram_we    = (state_ff == S_UPD) || (state_ff == S_CLR);
         ram_waddr = t_ff;
         ram_wdata = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      frame_count_in = frame_count_ff;
      mt_in          = mt_ff;
      s1_valid_in    = count_pix;
      t_in           = t_ff;
      w_in           = w_ff;
      m_in           = m_ff;
      mul_a_in       = mul_a_ff << 1;
      mul_b_in       = mul_b_ff >> 1;
      mul_acc_in     = mul_step;
      mul_cnt_in     = mul_cnt_ff + otsu_pkg::MCNT_W'(1);
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_ACC: begin
            mul_cnt_in = '0;
            if (count_pix) begin
               frame_count_in = frame_count_ff + otsu_pkg::CNT_W'(1);
               mt_in          = mt_ff + otsu_pkg::SUM_W'(lvl);
            end
            if (accept && req_last_pixel) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            mul_cnt_in = '0;
            state_in   = S_RD;
         end
         S_RD: begin
            mul_cnt_in = '0;
            state_in   = S_BIN;
         end
         S_BIN: begin
            mul_cnt_in = '0;
            state_in   = skip_lvl ? S_UPD : S_PRD;
         end
         S_PRD: begin
            mul_cnt_in = '0;
            state_in   = S_DEN;
         end
         S_DEN: begin
            mul_a_in   = otsu_pkg::CMP_W'(d_val);
            mul_b_in   = d_val;
            mul_acc_in = '0;
            mul_cnt_in = '0;
            state_in   = S_SQ;
         end
         S_SQ: begin
            if (mul_last) begin
               mul_a_in   = otsu_pkg::CMP_W'(mul_step[otsu_pkg::NUM_W-1:0]);
               mul_b_in   = otsu_pkg::D_W'(best_den_ff);
               mul_acc_in = '0;
               mul_cnt_in = '0;
               state_in   = S_LHS;
            end
         end
         S_LHS: begin
            if (mul_last) begin
               mul_a_in   = otsu_pkg::CMP_W'(best_num_ff);
               mul_b_in   = otsu_pkg::D_W'(den_ff);
               mul_acc_in = '0;
               mul_cnt_in = '0;
               state_in   = S_RHS;
            end
         end
         S_RHS: begin
            if (mul_last) begin
               mul_cnt_in = '0;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            mul_acc_in = mul_acc_ff;
            mul_cnt_in = '0;
            state_in   = S_UPD;
         end
         S_UPD: begin
            mul_cnt_in = '0;
            w_in       = w_ff + bin_ff;
            m_in       = m_ff + otsu_pkg::SUM_W'(t_ff) * otsu_pkg::SUM_W'(bin_ff);
            if (t_ff == otsu_pkg::TOP_LEVEL) begin
               state_in = S_FIN;
            end else begin
               t_in     = t_ff + otsu_pkg::PIX_W'(1);
               state_in = S_RD;
            end
         end
         S_FIN: begin
            mul_cnt_in = '0;
            if (!rsp_valid_ff) begin
               rsp_valid_in   = 1'b1;
               frame_count_in = '0;
               mt_in          = '0;
               t_in           = '0;
               w_in           = '0;
               m_in           = '0;
               state_in       = S_ACC;
            end
         end
         S_CLR: begin
            mul_cnt_in = '0;
            t_in       = t_ff + otsu_pkg::PIX_W'(1);
            if (t_ff == otsu_pkg::PIX_W'(otsu_pkg::BIN_SLOTS - 1)) begin
               state_in = S_ACC;
            end
         end
         default: begin
            state_in = S_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLR;
         frame_count_ff <= '0;
         mt_ff          <= '0;
         s1_valid_ff    <= 1'b0;
         wl_valid_ff    <= 1'b0;
         t_ff           <= '0;
         w_ff           <= '0;
         m_ff           <= '0;
         mul_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         best_num_ff    <= '0;
         best_den_ff    <= otsu_pkg::DEN_W'(1);
         best_t_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         mt_ff          <= mt_in;
         s1_valid_ff    <= s1_valid_in;
         wl_valid_ff    <= s1_valid_ff;
         t_ff           <= t_in;
         w_ff           <= w_in;
         m_ff           <= m_in;
         mul_cnt_ff     <= mul_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (state_ff == S_CMP && best_upd) begin
            best_num_ff <= num_ff;
            best_den_ff <= den_ff;
            best_t_ff   <= t_ff;
         end else if (state_ff == S_FIN && !rsp_valid_ff) begin
            best_num_ff <= '0;
            best_den_ff <= otsu_pkg::DEN_W'(1);
            best_t_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= lvl;
      wl_addr_ff <= s1_addr_ff;
      wl_data_ff <= inc;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      if (state_ff == S_BIN) begin
         bin_ff <= ram_rdata;
         a_ff   <= otsu_pkg::D_W'(mt_ff) * otsu_pkg::D_W'(w_ff);
      end
      if (state_ff == S_PRD) begin
         b_ff <= otsu_pkg::D_W'(m_ff) * otsu_pkg::D_W'(frame_count_ff);
      end
      if (state_ff == S_DEN) begin
         den_ff <= otsu_pkg::DEN_W'(w_ff) * otsu_pkg::DEN_W'(frame_count_ff - w_ff);
      end
      if (state_ff == S_SQ && mul_last) begin
         num_ff <= mul_step[otsu_pkg::NUM_W-1:0];
      end
      if (state_ff == S_LHS && mul_last) begin
         lhs_ff <= mul_step;
      end
      if (state_ff == S_FIN && !rsp_valid_ff) begin
         rsp_threshold_ff <= best_t_ff;
      end
   end

`ifndef SYNTHESIS
   a_last_wait: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_pixel |=> state_ff == S_WAIT)
      else $error("last word did not start the drain");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == S_ACC || state_ff == S_WAIT))
      else $error("histogram update pending during scan");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      frame_count_ff <= otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS))
      else $error("frame count above cap");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_cnt_ff != '0 |-> (state_ff == S_SQ || state_ff == S_LHS || state_ff == S_RHS))
      else $error("multiplier stepping outside a product state");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      best_den_ff != '0)
      else $error("best denominator is zero");
`endif

endmodule
